[hdl/abbg_pkg.sv]
// ----------------------------------------------------------------------------
// abbg_pkg
// Shared types and constants for the angle bang-bang position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package abbg_pkg;

  // angle scaling
  localparam logic [9:0] ANGLE_OFFSET      = 10'd100;
  localparam int         COUNTS_PER_DEGREE = 4;
  localparam logic [7:0] MAX_DEG           = 8'd180;
  localparam logic [7:0] WRAP_LIMIT        = 8'd200;

  // position loop
  localparam logic [7:0] DOWN_OFFSET = 8'd15;
  localparam logic [7:0] FULL_DRIVE  = 8'd255;

  // configuration reset values
  localparam logic [9:0]  OC_THRESHOLD_RST    = 10'd512;
  localparam logic [15:0] TRIP_TICKS_RST      = 16'd50;
  localparam logic [15:0] RELEASE_TICKS_RST   = 16'd20;
  localparam logic [7:0]  DEAD_BAND_START_RST = 8'd2;
  localparam logic [7:0]  DEAD_BAND_HOLD_RST  = 8'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OC_THRESHOLD    = 3'd0,
    REG_TRIP_TICKS      = 3'd1,
    REG_RELEASE_TICKS   = 3'd2,
    REG_DEAD_BAND_START = 3'd3,
    REG_DEAD_BAND_HOLD  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_STOP        = 3'd0,
    ST_UP          = 3'd1,
    ST_DOWN        = 3'd2,
    ST_DONE        = 3'd3,
    ST_OVERCURRENT = 3'd4
  } status_t;

  typedef struct packed {
    logic       action;
    logic [9:0] current_sample;
    logic [9:0] angle_sample;
    logic [7:0] target_angle;
    logic [7:0] repeat_count;
    logic       enable;
  } in_t;

  typedef struct packed {
    logic [7:0] drive;
    logic       pull_direction;
    logic [2:0] motor_status;
    logic [7:0] angle_degrees;
    logic [7:0] position_error;
  } out_t;

  typedef struct packed {
    logic [9:0]  oc_threshold;
    logic [15:0] trip_ticks;
    logic [15:0] release_ticks;
    logic [7:0]  dead_band_start;
    logic [7:0]  dead_band_hold;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/abbg_cfg.sv]
// ----------------------------------------------------------------------------
// abbg_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module abbg_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [abbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [abbg_pkg::CFG_DATA_W-1:0] cfg_data,
  output abbg_pkg::cfg_t                       cfg
);
  import abbg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oc_threshold    <= OC_THRESHOLD_RST;
      cfg_r.trip_ticks      <= TRIP_TICKS_RST;
      cfg_r.release_ticks   <= RELEASE_TICKS_RST;
      cfg_r.dead_band_start <= DEAD_BAND_START_RST;
      cfg_r.dead_band_hold  <= DEAD_BAND_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OC_THRESHOLD:    cfg_r.oc_threshold    <= cfg_data[9:0];
        REG_TRIP_TICKS:      cfg_r.trip_ticks      <= cfg_data;
        REG_RELEASE_TICKS:   cfg_r.release_ticks   <= cfg_data;
        REG_DEAD_BAND_START: cfg_r.dead_band_start <= cfg_data[7:0];
        REG_DEAD_BAND_HOLD:  cfg_r.dead_band_hold  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/abbg_scale.sv]
// ----------------------------------------------------------------------------
// abbg_scale
// Converts an angle sensor sample to whole degrees with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module abbg_scale (
  input  wire logic [9:0] angle_sample,
  output logic      [7:0] angle_deg
);
  import abbg_pkg::*;

  logic [9:0] diff;
  logic [9:0] quot;

  assign diff = angle_sample - ANGLE_OFFSET;
  assign quot = 10'(diff / COUNTS_PER_DEGREE);

  always_comb begin
    if (angle_sample < ANGLE_OFFSET) begin
      angle_deg = '0;
    end else if (quot > {2'b00, WRAP_LIMIT}) begin
      // sensor wrapped past its range
      angle_deg = '0;
    end else if (quot > {2'b00, MAX_DEG}) begin
      angle_deg = MAX_DEG;
    end else begin
      angle_deg = quot[7:0];
    end
  end

endmodule

`default_nettype wire

[hdl/abbg_ctrl.sv]
// ----------------------------------------------------------------------------
// abbg_ctrl
// Controller state: overcurrent trip, bang-bang position loop and repeats.
// ----------------------------------------------------------------------------
`default_nettype none

module abbg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  abbg_pkg::in_t       item,
  input  abbg_pkg::cfg_t      cfg,
  input  wire logic [7:0]     angle_deg,
  output abbg_pkg::out_t      res
);
  import abbg_pkg::*;

  logic [15:0] ocnt_r, ocnt_nxt;
  logic [7:0]  angle_r, angle_nxt;
  logic [7:0]  sp_r, sp_nxt;
  logic [7:0]  base_r, base_nxt;
  logic [7:0]  reps_r, reps_nxt;
  logic        moving_r, moving_nxt;
  status_t     status_r, status_nxt;
  logic [7:0]  err_r, err_nxt;
  logic [7:0]  best_r, best_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  db_r, db_nxt;
  logic        up_next_r, up_next_nxt;
  logic [7:0]  drive_r, drive_nxt;
  logic        dir_r, dir_nxt;

  logic        over;
  logic [15:0] ocnt_inc;
  logic        trip;
  logic [7:0]  down_sp;

  assign over     = item.current_sample > cfg.oc_threshold;
  assign ocnt_inc = (ocnt_r == 16'hFFFF) ? ocnt_r : ocnt_r + 16'd1;
  assign trip     = over && (cfg.trip_ticks != '0) && (ocnt_inc == cfg.trip_ticks);
  assign down_sp  = (base_r >= DOWN_OFFSET) ? base_r - DOWN_OFFSET : '0;

  always_comb begin
    ocnt_nxt    = ocnt_r;
    angle_nxt   = angle_r;
    sp_nxt      = sp_r;
    base_nxt    = base_r;
    reps_nxt    = reps_r;
    moving_nxt  = moving_r;
    status_nxt  = status_r;
    err_nxt     = err_r;
    best_nxt    = best_r;
    timer_nxt   = timer_r;
    db_nxt      = db_r;
    up_next_nxt = up_next_r;
    drive_nxt   = drive_r;
    dir_nxt     = dir_r;

    if (item.action == ACT_LOAD) begin
      sp_nxt      = item.target_angle;
      base_nxt    = item.target_angle;
      reps_nxt    = item.repeat_count;
      moving_nxt  = item.enable;
      db_nxt      = cfg.dead_band_start;
      best_nxt    = '0;
      up_next_nxt = 1'b0;
      if (!item.enable) begin
        status_nxt = ST_STOP;
        drive_nxt  = '0;
      end
    end else begin
      angle_nxt = angle_deg;
      if (over) begin
        ocnt_nxt = ocnt_inc;
        if (trip) begin
          moving_nxt = 1'b0;
          status_nxt = ST_OVERCURRENT;
          sp_nxt     = '0;
          reps_nxt   = '0;
          ocnt_nxt   = '0;
        end
      end else begin
        ocnt_nxt = '0;
      end

      if (!moving_nxt) begin
        drive_nxt = '0;
      end else begin
        // moving is still set, so no trip happened and sp_r is current
        if ({1'b0, angle_deg} + {1'b0, db_r} <= {1'b0, sp_r}) begin
          err_nxt    = sp_r - angle_deg;
          dir_nxt    = 1'b1;
          drive_nxt  = FULL_DRIVE;
          status_nxt = ST_UP;
        end else if (angle_deg > db_r && angle_deg - db_r >= sp_r) begin
          err_nxt = angle_deg - sp_r;
          dir_nxt = 1'b0;
          if (timer_r == cfg.release_ticks) begin
            // drive only while the error keeps shrinking
            drive_nxt = (err_nxt < best_r) ? FULL_DRIVE : '0;
            if (err_nxt < best_r || best_r == '0) begin
              best_nxt = err_nxt;
            end
            timer_nxt = '0;
          end else begin
            timer_nxt = timer_r + 16'd1;
          end
          status_nxt = ST_DOWN;
        end else begin
          drive_nxt  = '0;
          db_nxt     = cfg.dead_band_hold;
          status_nxt = ST_DONE;
        end

        // automatic down/up repetition once the target is held
        if (reps_r != '0 && status_nxt == ST_DONE) begin
          db_nxt = cfg.dead_band_start;
          if (up_next_r) begin
            sp_nxt      = base_r;
            up_next_nxt = 1'b0;
            reps_nxt    = reps_r - 8'd1;
          end else begin
            sp_nxt      = down_sp;
            up_next_nxt = 1'b1;
            best_nxt    = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r    <= '0;
      angle_r   <= '0;
      sp_r      <= '0;
      base_r    <= '0;
      reps_r    <= '0;
      moving_r  <= 1'b0;
      status_r  <= ST_STOP;
      err_r     <= '0;
      best_r    <= '0;
      timer_r   <= '0;
      db_r      <= DEAD_BAND_START_RST;
      up_next_r <= 1'b0;
      drive_r   <= '0;
      dir_r     <= 1'b0;
    end else if (step) begin
      ocnt_r    <= ocnt_nxt;
      angle_r   <= angle_nxt;
      sp_r      <= sp_nxt;
      base_r    <= base_nxt;
      reps_r    <= reps_nxt;
      moving_r  <= moving_nxt;
      status_r  <= status_nxt;
      err_r     <= err_nxt;
      best_r    <= best_nxt;
      timer_r   <= timer_nxt;
      db_r      <= db_nxt;
      up_next_r <= up_next_nxt;
      drive_r   <= drive_nxt;
      dir_r     <= dir_nxt;
    end
  end

  // result reports the state after this transaction
  always_comb begin
    res.drive          = drive_nxt;
    res.pull_direction = dir_nxt;
    res.motor_status   = status_nxt;
    res.angle_degrees  = angle_nxt;
    res.position_error = err_nxt;
  end

`ifndef NO_ASSERTIONS
  a_drive_levels: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r == '0 || drive_r == FULL_DRIVE)
    else $error("drive level is neither off nor full");

  a_disabled_off: assert property (@(posedge clk) disable iff (!rst_n)
    !moving_r |-> drive_r == '0)
    else $error("drive on while movement disabled");

  a_trip_stops: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.action == ACT_TICK && trip |=> !moving_r && status_r == ST_OVERCURRENT)
    else $error("overcurrent trip did not stop the motor");
`endif

endmodule

`default_nettype wire

[hdl/angle_bang_bang_position_control.sv]
// ----------------------------------------------------------------------------
// angle_bang_bang_position_control
// On/off angle position controller with overcurrent trip and auto repeat.
// ----------------------------------------------------------------------------
//   channel   ports                               direction
//   input     in_valid / in_ready / in_data       tick or load command in
//   result    out_valid / out_ready / out_data    one result per transaction
//   config    cfg_we / cfg_index / cfg_data       register write, no wait
//
// One transaction per cycle sustained while results are taken; an accepted
// input is held in the input register, then the controller update writes its
// result into the result register, where it becomes valid. Reset is
// synchronous and clears all control state and the configuration to its
// defaults. A stalled result holds in the result register while the input
// register still takes one more item.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_bang_bang_position_control (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  abbg_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output abbg_pkg::out_t                       out_data,
  input  wire logic                            cfg_we,
  input  wire logic [abbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [abbg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import abbg_pkg::*;

  logic  s1_v_r;
  in_t   s1_data_r;
  logic  out_v_r;
  out_t  out_data_r;
  logic  adv;
  cfg_t  cfg;
  logic [7:0] angle_deg;
  out_t  res;

  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || adv;

  abbg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  abbg_scale u_scale (
    .angle_sample (s1_data_r.angle_sample),
    .angle_deg    (angle_deg)
  );

  abbg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .item      (s1_data_r),
    .cfg       (cfg),
    .angle_deg (angle_deg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_data_r))
    else $error("input stage dropped a waiting transaction");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_v_r))
    else $error("result appeared with no transaction behind it");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(out_data_r))
    else $error("stalled result changed before it was taken");
`endif

endmodule

`default_nettype wire
